@@ hdl/fcr_pkg.sv @@
// Shared types and constants for the framed command receiver and responder.
package fcr_pkg;

  // Frame limits
  localparam int unsigned MAX_FRAME_BYTES = 128;
  localparam int unsigned CNT_W           = 9;   // count one bit wider than storage
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

  // Framing bytes
  localparam logic [7:0] SOF_BYTE   = 8'h0C;
  localparam logic [7:0] EOF_BYTE   = 8'h0D;
  localparam logic [7:0] HDR1_BYTE  = 8'h1A;
  localparam logic [7:0] HDR2_BYTE  = 8'h1B;
  localparam logic [7:0] BASE_LEN   = 8'h08;

  // Command codes received
  localparam logic [7:0] CMD_PING   = 8'h01;
  localparam logic [7:0] CMD_QUERY  = 8'hBB;
  localparam logic [7:0] CMD_SIL_A  = 8'h03;
  localparam logic [7:0] CMD_SIL_B  = 8'h05;
  localparam logic [7:0] CMD_SIL_C  = 8'h09;
  localparam logic [7:0] CMD_SIL_D  = 8'hB0;

  // Reply codes
  localparam logic [7:0] RSP_PING   = 8'h02;
  localparam logic [7:0] RSP_QUERY  = 8'hBC;
  localparam logic [7:0] RSP_ERROR  = 8'hE0;
  localparam logic [7:0] RSP_OVF    = 8'hE2;

  // Error reply data codes
  localparam logic [7:0] ERR_CHKSUM = 8'h02;
  localparam logic [7:0] ERR_UNKCMD = 8'h03;
  localparam logic [7:0] OVF_D0     = 8'h10;
  localparam logic [7:0] OVF_D1     = 8'h11;
  localparam logic [7:0] OVF_D2     = 8'h12;

  // One queued reply: code plus up to three data bytes
  typedef struct packed {
    logic [7:0] cmd;
    logic [1:0] ndata;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
  } reply_t;

  // Push side of the reply queue
  typedef struct packed {
    logic   push;
    reply_t rsp;
  } reply_push_t;

endpackage

@@ hdl/fcr_rx.sv @@
// Front end: frame parser that turns received bytes into reply descriptors.
module fcr_rx import fcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        q_full,
  output reply_push_t q_wr
);

  logic [7:0]  count_r,  count_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  sum_r,    sum_nxt;
  logic [7:0]  prev_r,   prev_nxt;
  logic [7:0]  prev2_r,  prev2_nxt;
  logic [7:0]  cmd_r,    cmd_nxt;

  logic             accept;
  logic [7:0]       b;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      len_upd;
  logic [7:0]       sum_upd;
  logic [7:0]       cmd_upd;
  logic [7:0]       want;
  logic             closes;
  logic             ovf;
  logic             chk_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_rx_byte;

  // Field capture and checksum for the byte at hand
  always_comb begin
    cnt_inc = {1'b0, count_r} + CNT_W'(1);
    len_upd = length_r;
    if (count_r == 8'd4) len_upd[15:8] = b;
    if (count_r == 8'd5) len_upd[7:0]  = b;
    cmd_upd = (count_r == 8'd3) ? b : cmd_r;
    sum_upd = (count_r >= 8'd3) ? (sum_r + prev2_r) : sum_r;
    want    = 8'd0 - sum_upd;
    chk_ok  = (want == prev_r);
    closes  = (b == EOF_BYTE) && (cnt_inc >= CNT_W'(6)) &&
              (len_upd == {{(16-CNT_W){1'b0}}, cnt_inc});
    ovf     = cnt_inc > CNT_W'(MAX_FRAME_BYTES);
  end

  // Next receive state
  always_comb begin
    count_nxt  = count_r;
    length_nxt = length_r;
    sum_nxt    = sum_r;
    prev_nxt   = prev_r;
    prev2_nxt  = prev2_r;
    cmd_nxt    = cmd_r;
    if (accept) begin
      if (count_r == 8'd0) begin
        if (b == SOF_BYTE) begin
          count_nxt  = 8'd1;
          length_nxt = '0;
          sum_nxt    = '0;
          prev_nxt   = b;
          prev2_nxt  = '0;
          cmd_nxt    = '0;
        end
      end else if (ovf || closes) begin
        count_nxt  = '0;
        length_nxt = '0;
        sum_nxt    = '0;
        prev_nxt   = '0;
        prev2_nxt  = '0;
        cmd_nxt    = '0;
      end else begin
        count_nxt  = cnt_inc[7:0];
        length_nxt = len_upd;
        sum_nxt    = sum_upd;
        prev_nxt   = b;
        prev2_nxt  = prev_r;
        cmd_nxt    = cmd_upd;
      end
    end
  end

  // Classify a finished frame into a reply
  always_comb begin
    q_wr.push      = 1'b0;
    q_wr.rsp.cmd   = RSP_ERROR;
    q_wr.rsp.ndata = 2'd0;
    q_wr.rsp.d0    = '0;
    q_wr.rsp.d1    = '0;
    q_wr.rsp.d2    = '0;
    if (accept && count_r != 8'd0) begin
      if (ovf) begin
        q_wr.push      = 1'b1;
        q_wr.rsp.cmd   = RSP_OVF;
        q_wr.rsp.ndata = 2'd3;
        q_wr.rsp.d0    = OVF_D0;
        q_wr.rsp.d1    = OVF_D1;
        q_wr.rsp.d2    = OVF_D2;
      end else if (closes) begin
        if (!chk_ok) begin
          q_wr.push      = 1'b1;
          q_wr.rsp.ndata = 2'd3;
          q_wr.rsp.d0    = ERR_CHKSUM;
          q_wr.rsp.d1    = want;
          q_wr.rsp.d2    = prev_r;
        end else begin
          unique case (cmd_upd) inside
            CMD_PING: begin
              q_wr.push    = 1'b1;
              q_wr.rsp.cmd = RSP_PING;
            end
            CMD_QUERY: begin
              q_wr.push    = 1'b1;
              q_wr.rsp.cmd = RSP_QUERY;
            end
            CMD_SIL_A, CMD_SIL_B, CMD_SIL_C, CMD_SIL_D: begin
              q_wr.push = 1'b0;
            end
            default: begin
              q_wr.push      = 1'b1;
              q_wr.rsp.ndata = 2'd1;
              q_wr.rsp.d0    = ERR_UNKCMD;
            end
          endcase
        end
      end
    end
  end

  // Receive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      length_r <= '0;
      sum_r    <= '0;
      prev_r   <= '0;
      prev2_r  <= '0;
      cmd_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      length_r <= length_nxt;
      sum_r    <= sum_nxt;
      prev_r   <= prev_nxt;
      prev2_r  <= prev2_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

endmodule

@@ hdl/fcr_queue.sv @@
// Short reply descriptor queue between the parser and the transmitter.
module fcr_queue import fcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  reply_push_t q_wr,
  output logic        q_full,
  input  logic        q_pop,
  output logic        q_empty,
  output reply_t      q_head
);

  reply_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r,   fill_nxt;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = mem_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) fill_nxt = fill_r + (QPTR_W+1)'(1);
    if (do_pop && !do_push) fill_nxt = fill_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.rsp;
  end

endmodule

@@ hdl/fcr_tx.sv @@
// Back end: serializes queued replies into framed bytes with a checksum.
module fcr_tx import fcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  reply_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  reply_t     cur_r,   cur_nxt;
  logic       busy_r,  busy_nxt;
  logic [3:0] idx_r,   idx_nxt;
  logic [7:0] sum_r,   sum_nxt;
  logic       ovld_r,  ovld_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;

  logic       slot_free;
  logic       emit;
  logic [3:0] chk_pos;
  logic [3:0] eof_pos;
  logic [3:0] dsel;
  logic [7:0] byte_cur;
  logic       is_last;

  assign slot_free = !ovld_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign chk_pos   = 4'd6 + {2'b00, cur_r.ndata};
  assign eof_pos   = 4'd7 + {2'b00, cur_r.ndata};
  assign dsel      = idx_r - 4'd6;
  assign is_last   = (idx_r == eof_pos);
  assign q_pop     = !q_empty && (!busy_r || (emit && is_last));

  // Byte at the current reply position
  always_comb begin
    if (idx_r == eof_pos) begin
      byte_cur = EOF_BYTE;
    end else if (idx_r == chk_pos) begin
      byte_cur = 8'd0 - sum_r;
    end else begin
      case (idx_r)
        4'd0:    byte_cur = SOF_BYTE;
        4'd1:    byte_cur = HDR1_BYTE;
        4'd2:    byte_cur = HDR2_BYTE;
        4'd3:    byte_cur = cur_r.cmd;
        4'd4:    byte_cur = 8'd0;
        4'd5:    byte_cur = BASE_LEN + {6'd0, cur_r.ndata};
        default: begin
          case (dsel[1:0])
            2'd0:    byte_cur = cur_r.d0;
            2'd1:    byte_cur = cur_r.d1;
            default: byte_cur = cur_r.d2;
          endcase
        end
      endcase
    end
  end

  // Sequencer and output register
  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    ovld_nxt  = ovld_r && !out_ready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (emit) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = byte_cur;
      olast_nxt = is_last;
      idx_nxt   = idx_r + 4'd1;
      if (idx_r != 4'd0 && idx_r < chk_pos) sum_nxt = sum_r + byte_cur;
      if (is_last) busy_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      idx_r  <= '0;
      sum_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ovld_r;
  assign out_tx_byte   = obyte_r;
  assign out_last_byte = olast_r;

endmodule

@@ hdl/framed_command_receiver_responder_unit.sv @@
// Framed command receiver and responder: parser, reply queue and transmitter.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per item.
// The parser takes an item every cycle while the four-entry reply queue has
// room; in_ready drops only when the queue is full.
// Output channel (out_valid/out_ready/out_tx_byte/out_last_byte): one reply
// byte per item, out_last_byte high on the closing 0x0D of each reply.
// A reply's first byte passes the queue, the reply and output registers after
// the frame's closing (or overflowing) byte is accepted, given an idle
// transmitter. The transmitter sends one byte per cycle while out_ready is
// high; a reply is 8, 9 or 11 bytes and the next reply follows with no gap.
// Input rate is one byte per cycle, limited over a long run by reply draining.
// Reset (rst_n low at a clock edge) returns the parser to idle, waiting for
// a start byte, and empties the queue and the transmitter.
// When the receiver stalls (out_ready low) the held byte stays on the port;
// the queue absorbs up to four replies before in_ready is withdrawn.
module framed_command_receiver_responder_unit import fcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  reply_push_t q_wr;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  reply_t      q_head;

  // Front end
  fcr_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  // Reply queue
  fcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Back end
  fcr_tx u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
